// File: src/int_to_decimal_ascii_assert.svh
// assertion macros shared by the int_to_decimal_ascii modules
`ifndef INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define ITDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("itda assertion failed");

// next-cycle implication, disabled while reset is high
`define ITDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("itda assertion failed");

`endif

// File: src/itda_pkg.sv
// types and constants for the integer to decimal ascii converter
`default_nettype none

package itda_pkg;

   localparam int VALUE_BITS = 32;
   // bits of magnitude consumed per conversion step
   localparam int STEP_BITS  = 4;
   localparam int STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int MAG_BITS   = STEPS * STEP_BITS;
   // decimal digits of 2^(VALUE_BITS-1)
   localparam int DIGITS     = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int BCD_BITS   = DIGITS * 4;
   localparam int STEP_W     = $clog2(STEPS);
   localparam int IDX_W      = $clog2(DIGITS);

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [3:0] DABBLE_MIN = 4'd5;
   localparam logic [3:0] DABBLE_ADD = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic show_sign;
      logic digit_phase;
      logic digit_beat;
   } ctrl_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic negative;
      logic last_digit;
   } ctrl_sts_type;

endpackage

`default_nettype wire

// File: src/itda_req_if.sv
// input channel: one signed integer per beat
`default_nettype none

interface itda_req_if;
   logic                                valid;
   logic                                ready;
   logic signed [itda_pkg::VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

// File: src/itda_rsp_if.sv
// result channel: one ascii character per beat
`default_nettype none

interface itda_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

// File: src/itda_ctrl.sv
// controller state machine for the integer to decimal ascii converter
`default_nettype none

`include "int_to_decimal_ascii_assert.svh"

module itda_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire itda_pkg::ctrl_sts_type sts,
   output itda_pkg::ctrl_cmd_type      cmd
);

   itda_pkg::state_type state_ff;
   itda_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= itda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         itda_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = itda_pkg::ST_CONVERT;
            end
         end
         itda_pkg::ST_CONVERT: begin
            cmd.step = 1'b1;
            if (sts.conv_done) begin
               state_in = sts.negative ? itda_pkg::ST_SIGN : itda_pkg::ST_DIGITS;
            end
         end
         itda_pkg::ST_SIGN: begin
            rsp_valid     = 1'b1;
            cmd.show_sign = 1'b1;
            if (rsp_ready) begin
               state_in = itda_pkg::ST_DIGITS;
            end
         end
         itda_pkg::ST_DIGITS: begin
            rsp_valid       = 1'b1;
            cmd.digit_phase = 1'b1;
            if (rsp_ready) begin
               cmd.digit_beat = 1'b1;
               if (sts.last_digit) begin
                  state_in = itda_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = itda_pkg::ST_IDLE;
         end
      endcase
   end

   `ITDA_ASSERT_NOW(a_ready_valid_excl, clock, reset, req_ready, !rsp_valid)
   `ITDA_ASSERT_NEXT(a_load_converts, clock, reset, req_valid && req_ready,
      state_ff == itda_pkg::ST_CONVERT)
   `ITDA_ASSERT_NEXT(a_sign_then_digits, clock, reset,
      state_ff == itda_pkg::ST_SIGN && rsp_ready, state_ff == itda_pkg::ST_DIGITS)

endmodule

`default_nettype wire

// File: src/itda_datapath.sv
// magnitude, bcd conversion and character selection datapath
`default_nettype none

`include "int_to_decimal_ascii_assert.svh"

module itda_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic signed [itda_pkg::VALUE_BITS-1:0] req_value,
   input  wire itda_pkg::ctrl_cmd_type                 cmd,
   output itda_pkg::ctrl_sts_type                      sts,
   output logic [7:0]                                  rsp_char_code,
   output logic                                        rsp_last_char
);

   logic [itda_pkg::MAG_BITS-1:0] mag_ff;
   logic [itda_pkg::MAG_BITS-1:0] mag_in;
   logic [itda_pkg::BCD_BITS-1:0] bcd_ff;
   logic [itda_pkg::BCD_BITS-1:0] bcd_in;
   logic [itda_pkg::STEP_W-1:0]   step_ff;
   logic [itda_pkg::STEP_W-1:0]   step_in;
   logic [itda_pkg::IDX_W-1:0]    idx_ff;
   logic [itda_pkg::IDX_W-1:0]    idx_in;
   logic                          neg_ff;
   logic                          neg_in;
   logic                          first_ff;
   logic                          first_in;

   logic [itda_pkg::VALUE_BITS-1:0] raw_mag;
   logic [itda_pkg::BCD_BITS-1:0]   dab_bcd;
   logic [itda_pkg::MAG_BITS-1:0]   dab_mag;
   logic [itda_pkg::IDX_W-1:0]      lead_idx;
   logic [itda_pkg::IDX_W-1:0]      emit_idx;
   logic [3:0]                      emit_digit;

   // two's complement magnitude, taken unsigned so the most negative value fits
   always_comb begin
      raw_mag = req_value[itda_pkg::VALUE_BITS-1]
         ? (~req_value) + itda_pkg::VALUE_BITS'(1) : req_value;
   end

   // shift-add-3 over STEP_BITS magnitude bits
   always_comb begin
      logic [itda_pkg::BCD_BITS-1:0] b;
      logic [itda_pkg::MAG_BITS-1:0] m;
      b = bcd_ff;
      m = mag_ff;
      for (int k = 0; k < itda_pkg::STEP_BITS; k++) begin
         for (int d = 0; d < itda_pkg::DIGITS; d++) begin
            if (b[d*4 +: 4] >= itda_pkg::DABBLE_MIN) begin
               b[d*4 +: 4] = b[d*4 +: 4] + itda_pkg::DABBLE_ADD;
            end
         end
         {b, m} = {b[itda_pkg::BCD_BITS-2:0], m, 1'b0};
      end
      dab_bcd = b;
      dab_mag = m;
   end

   // highest nonzero digit, digit zero when the value is zero
   always_comb begin
      lead_idx = '0;
      for (int d = 1; d < itda_pkg::DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            lead_idx = itda_pkg::IDX_W'(d);
         end
      end
   end

   always_comb begin
      emit_idx   = first_ff ? lead_idx : idx_ff;
      emit_digit = bcd_ff[emit_idx*4 +: 4];
   end

   always_comb begin
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      idx_in   = idx_ff;
      neg_in   = neg_ff;
      first_in = first_ff;
      if (cmd.load) begin
         mag_in   = itda_pkg::MAG_BITS'(raw_mag);
         bcd_in   = '0;
         step_in  = '0;
         neg_in   = req_value[itda_pkg::VALUE_BITS-1];
         first_in = 1'b1;
      end else if (cmd.step) begin
         mag_in  = dab_mag;
         bcd_in  = dab_bcd;
         step_in = step_ff + itda_pkg::STEP_W'(1);
      end else if (cmd.digit_beat) begin
         idx_in   = emit_idx - itda_pkg::IDX_W'(1);
         first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      bcd_ff   <= bcd_in;
      step_ff  <= step_in;
      idx_ff   <= idx_in;
      neg_ff   <= neg_in;
      first_ff <= first_in;
   end

   always_comb begin
      sts.conv_done  = step_ff == itda_pkg::STEP_W'(itda_pkg::STEPS - 1);
      sts.negative   = neg_ff;
      sts.last_digit = emit_idx == '0;
      rsp_char_code  = cmd.show_sign ? itda_pkg::CHAR_MINUS
                                     : itda_pkg::CHAR_ZERO + {4'd0, emit_digit};
      rsp_last_char  = !cmd.show_sign && (emit_idx == '0);
   end

   `ITDA_ASSERT_NOW(a_digit_decimal, clock, reset, cmd.digit_phase, emit_digit <= 4'd9)
   `ITDA_ASSERT_NEXT(a_load_sets_first, clock, reset, cmd.load, first_ff && step_ff == '0)

endmodule

`default_nettype wire

// File: src/int_to_decimal_ascii.sv
// top level: signed integer to decimal ascii character stream
//
//   channel   dir   beat contents             accepted when
//   req_bus   in    value (signed)            valid && ready
//   rsp_bus   out   char_code, last_char      valid && ready
//
// one number is accepted, then passed through the 4-bit-per-cycle shift-add-3
// loop for bcd conversion, then sent one character per cycle while rsp_bus is
// ready, over the single character output path.
// synchronous reset returns the controller to idle and drops any number in flight.
// a stalled rsp_bus holds the current character; no new number is taken until
// the last character of the current one has left.
`default_nettype none

module int_to_decimal_ascii (
   input  wire logic    clock,
   input  wire logic    reset,
   itda_req_if.sink     req_bus,
   itda_rsp_if.source   rsp_bus
);

   itda_pkg::ctrl_cmd_type cmd;
   itda_pkg::ctrl_sts_type sts;

   itda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   itda_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_value     (req_bus.value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_char_code (rsp_bus.char_code),
      .rsp_last_char (rsp_bus.last_char)
   );

endmodule

`default_nettype wire
